// ----- hw/rtl/signed_int_to_decimal_ascii_macros.svh -----
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SIDTA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sidta check failed");

// next-cycle implication
`define SIDTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sidta check failed");

`endif

// ----- hw/rtl/sidta_pkg.sv -----
`timescale 1ns / 1ps
package sidta_pkg;

  localparam int unsigned NumDigits     = 10;
  localparam int unsigned BinW          = 32;
  localparam int unsigned BcdW          = 4 * NumDigits;
  localparam int unsigned DigIdxW       = $clog2(NumDigits);
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumStages     = BinW / StepsPerStage;
  localparam int unsigned CharW         = 7;

  localparam logic [CharW-1:0] AsciiZero  = 7'd48;
  localparam logic [CharW-1:0] AsciiMinus = 7'd45;

  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
  } dd_t;

  // shift-add-3 conversion, StepsPerStage bits
  function automatic dd_t dd_steps(input dd_t x);
    dd_t        r;
    logic [3:0] d;
    r = x;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int k = 0; k < NumDigits; k++) begin
        d = r.bcd[4*k +: 4];
        if (d >= 4'd5) begin
          r.bcd[4*k +: 4] = d + 4'd3;
        end
      end
      r.bcd = {r.bcd[BcdW-2:0], r.bin[BinW-1]};
      r.bin = {r.bin[BinW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sidta_dabble_stage.sv -----
`timescale 1ns / 1ps
module sidta_dabble_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sidta_pkg::dd_t  data_i,
  output logic            ready_o,
  output logic            valid_o,
  output sidta_pkg::dd_t  data_o,
  input  logic            ready_i
);
  import sidta_pkg::*;

  logic valid_q;
  dd_t  data_q;
  dd_t  data_d;

  assign ready_o = !valid_q || ready_i;
  assign data_d  = dd_steps(data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/sidta_serializer.sv -----
`timescale 1ns / 1ps
module sidta_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  sidta_pkg::dd_t              data_i,
  output logic                        ready_o,
  output logic                        strobe_o,
  output logic [sidta_pkg::CharW-1:0] character_o,
  output logic                        last_o
);
  import sidta_pkg::*;

  logic               act_q, act_d;
  logic               sign_q, sign_d;
  logic [DigIdxW-1:0] idx_q, idx_d;
  logic [BcdW-1:0]    bcd_q;
  logic [DigIdxW-1:0] top_idx;
  logic [3:0]         cur_dig;
  logic               load;

  always_comb begin
    top_idx = '0;
    for (int k = 0; k < NumDigits; k++) begin
      if (data_i.bcd[4*k +: 4] != 4'd0) begin
        top_idx = DigIdxW'(k);
      end
    end
  end

  assign cur_dig     = bcd_q[4*idx_q +: 4];
  assign strobe_o    = act_q;
  assign last_o      = act_q && !sign_q && (idx_q == '0);
  assign character_o = sign_q ? AsciiMinus : (AsciiZero + {3'b000, cur_dig});
  assign ready_o     = !act_q || last_o;
  assign load        = ready_o && valid_i;

  always_comb begin
    act_d  = act_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    if (act_q) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q != '0) begin
        idx_d = idx_q - 1'b1;
      end else begin
        act_d = 1'b0;
      end
    end
    if (load) begin
      act_d  = 1'b1;
      sign_d = data_i.neg;
      idx_d  = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      act_q  <= act_d;
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= data_i.bcd;
    end
  end

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// The first character of an item is strobed after the input register, four 8-bit conversion
// stages and the serializer registers, in that order.
// Throughput: one character per cycle; an item is 1 to 11 characters, and busy holds
// off start while the stages are backed up behind the serializer.
// Reset (async, active low) clears all valid bits; nothing is kept between items.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          value_i,
  output logic                        strobe_o,
  output logic [sidta_pkg::CharW-1:0] character_o,
  output logic                        last_o
);
  import sidta_pkg::*;

  logic st_valid [NumStages+1];
  logic st_ready [NumStages+1];
  dd_t  st_data  [NumStages+1];

  logic s0_valid_q;
  dd_t  s0_data_q;
  dd_t  s0_data_d;
  logic s0_ready;
  logic in_neg;

  assign s0_ready = !s0_valid_q || st_ready[0];
  assign busy     = !s0_ready;

  assign in_neg        = value_i[BinW-1];
  assign s0_data_d.neg = in_neg;
  assign s0_data_d.bcd = '0;
  assign s0_data_d.bin = in_neg ? (BinW'(0) - BinW'(value_i)) : BinW'(value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && start) begin
      s0_data_q <= s0_data_d;
    end
  end

  assign st_valid[0] = s0_valid_q;
  assign st_data[0]  = s0_data_q;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    sidta_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .data_i  (st_data[g]),
      .ready_o (st_ready[g]),
      .valid_o (st_valid[g+1]),
      .data_o  (st_data[g+1]),
      .ready_i (st_ready[g+1])
    );
  end

  sidta_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (st_valid[NumStages]),
    .data_i      (st_data[NumStages]),
    .ready_o     (st_ready[NumStages]),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// ----- hw/rtl/sidta_checker.sv -----
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"
module sidta_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy,
  input logic                        strobe_o,
  input logic [sidta_pkg::CharW-1:0] character_o,
  input logic                        last_o
);
  import sidta_pkg::*;

  logic is_digit;
  logic is_minus;

  assign is_digit = (character_o >= AsciiZero) && (character_o <= AsciiZero + 7'd9);
  assign is_minus = (character_o == AsciiMinus);

  `SIDTA_ASSERT_NOW(a_char_legal, strobe_o, is_digit || is_minus)
  `SIDTA_ASSERT_NOW(a_last_is_digit, strobe_o && last_o, is_digit)
  `SIDTA_ASSERT_NEXT(a_run_contiguous, strobe_o && !last_o, strobe_o)
  `SIDTA_ASSERT_NEXT(a_minus_then_digit, strobe_o && is_minus, strobe_o && is_digit)
  `SIDTA_ASSERT_NOW(a_busy_while_emitting, busy, strobe_o && !last_o)

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (.*);
